### hw/rtl/svn_pkg.sv
// Shared types, register indexes and double-format helpers for the scaled
// vector norm unit. No dependencies.
`timescale 1ns / 1ps

package svn_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL_SCALE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_BOUND = 3'd4;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DEF_NAN   = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] IND_NAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;

  localparam logic signed [13:0] EXP_MIN  = -14'sd1022;
  localparam logic signed [13:0] EXP_MAX  = 14'sd1023;
  localparam logic signed [13:0] EXP_TINY = -14'sd1132;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_ADD,
    FOP_DIV,
    FOP_SQRT
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  typedef struct packed {
    logic [63:0] element;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] norm;
    logic        overflow;
  } out_item_t;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic signed [13:0] fp_exp(input logic [10:0] x);
    logic signed [13:0] v;
    v = $signed({3'b000, x}) - 14'sd1023;
    if (x == 11'd0) v = EXP_MIN;
    return v;
  endfunction

  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic r;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) r = 1'b0;
    else if (a[63] != b[63]) r = a[63];
    else if (!a[63]) r = a[62:0] < b[62:0];
    else r = a[62:0] > b[62:0];
    return r;
  endfunction

endpackage

### hw/rtl/svn_fpu.sv
// Iterative double-precision unit: multiply, add, divide and square root,
// one bit or one shift per cycle, with a normalize and round stage shared by multiply,
// add and divide (square root rounds in its own state). Depends on svn_pkg.
`timescale 1ns / 1ps

module svn_fpu import svn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fpu_req_t req_i,
  output fpu_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_ADD, F_DNA, F_DNB, F_DIV,
    F_SNRM, F_SODD, F_SQ, F_SFIN, F_NORM, F_RND
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic [107:0]       ua_r, ua_nxt, ub_r, ub_nxt, m_r, m_nxt;
  logic signed [13:0] e_r, e_nxt;
  logic               sgn_r, sgn_nxt, ssm_r, ssm_nxt, stk_r, stk_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [63:0]        res_r, res_nxt;
  logic               done_r, done_nxt;

  logic               sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [52:0]        ma, mb, mbig, msml;
  logic signed [13:0] ea, eb, ebig, dexp;
  logic [215:0]       wide;
  logic [107:0]       sml_al, acc, dr, asum, adif;
  logic [59:0]        remn, tq;
  logic [53:0]        mr;
  logic [52:0]        smant;
  logic               inc, sge;
  logic signed [13:0] ee, bsum, sexp;

  assign rsp_o.done = done_r;
  assign rsp_o.res  = res_r;

  always_comb begin
    sa     = req_i.a[63];
    sb     = req_i.b[63];
    nan_a  = is_nan(req_i.a);
    nan_b  = is_nan(req_i.b);
    inf_a  = is_inf(req_i.a);
    inf_b  = is_inf(req_i.b);
    zero_a = is_zero(req_i.a);
    zero_b = is_zero(req_i.b);
    ma     = {req_i.a[62:52] != 11'd0, req_i.a[51:0]};
    mb     = {req_i.b[62:52] != 11'd0, req_i.b[51:0]};
    ea     = fp_exp(req_i.a[62:52]);
    eb     = fp_exp(req_i.b[62:52]);
    if (ea >= eb) begin
      mbig = ma; msml = mb; ebig = ea; dexp = ea - eb;
    end else begin
      mbig = mb; msml = ma; ebig = eb; dexp = eb - ea;
    end
    wide = {2'b00, msml, 161'd0} >> dexp[6:0];
    if (dexp > 14'sd107) sml_al = {107'd0, msml != 53'd0};
    else sml_al = wide[215:108] | {107'd0, wide[107:0] != 108'd0};
  end

  always_comb begin
    acc   = m_r + (ub_r[0] ? ua_r : 108'd0);
    asum  = ua_r + ub_r;
    adif  = (ua_r >= ub_r) ? ua_r - ub_r : ub_r - ua_r;
    dr    = (ua_r[53:0] >= {1'b0, ub_r[52:0]}) ? ua_r - ub_r : ua_r;
    remn  = {ua_r[57:0], ub_r[53:52]};
    tq    = {4'd0, m_r[53:0], 2'b01};
    sge   = remn >= tq;
    smant = m_r[53:1];
    inc   = m_r[52] && ((m_r[51:0] != 52'd0) || stk_r || m_r[53]);
    mr    = {1'b0, m_r[105:53]} + {53'd0, inc};
    ee    = e_r + (mr[53] ? 14'sd1 : 14'sd0);
    bsum  = ee + 14'sd1023;
    sexp  = (e_r >>> 1) + 14'sd1049;
  end

  always_comb begin
    state_nxt = state_r;
    ua_nxt    = ua_r;
    ub_nxt    = ub_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    sgn_nxt   = sgn_r;
    ssm_nxt   = ssm_r;
    stk_nxt   = stk_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (req_i.start) begin
          done_nxt = 1'b1;
          unique case (req_i.op)
            FOP_MUL: begin
              if (nan_a) res_nxt = req_i.a | QUIET_BIT;
              else if (nan_b) res_nxt = req_i.b | QUIET_BIT;
              else if ((inf_a && zero_b) || (zero_a && inf_b)) res_nxt = IND_NAN;
              else if (inf_a || inf_b) res_nxt = {sa ^ sb, 11'h7FF, 52'd0};
              else if (zero_a || zero_b) res_nxt = {sa ^ sb, 63'd0};
              else begin
                done_nxt  = 1'b0;
                ua_nxt    = {55'd0, ma};
                ub_nxt    = {55'd0, mb};
                m_nxt     = '0;
                e_nxt     = ea + eb;
                sgn_nxt   = sa ^ sb;
                stk_nxt   = 1'b0;
                cnt_nxt   = 6'd53;
                state_nxt = F_MUL;
              end
            end
            FOP_ADD: begin
              if (nan_a) res_nxt = req_i.a | QUIET_BIT;
              else if (nan_b) res_nxt = req_i.b | QUIET_BIT;
              else if (inf_a && inf_b && (sa != sb)) res_nxt = IND_NAN;
              else if (inf_a) res_nxt = req_i.a;
              else if (inf_b) res_nxt = req_i.b;
              else if (zero_a && zero_b) res_nxt = {sa & sb, 63'd0};
              else begin
                done_nxt  = 1'b0;
                ua_nxt    = {2'b00, mbig, 53'd0};
                ub_nxt    = sml_al;
                e_nxt     = ebig;
                sgn_nxt   = (ea >= eb) ? sa : sb;
                ssm_nxt   = (ea >= eb) ? sb : sa;
                stk_nxt   = 1'b0;
                state_nxt = F_ADD;
              end
            end
            FOP_DIV: begin
              if (nan_a) res_nxt = req_i.a | QUIET_BIT;
              else if (nan_b) res_nxt = req_i.b | QUIET_BIT;
              else if (zero_b) res_nxt = zero_a ? DEF_NAN : {sa ^ sb, 11'h7FF, 52'd0};
              else if (inf_a) res_nxt = inf_b ? IND_NAN : {sa ^ sb, 11'h7FF, 52'd0};
              else if (inf_b || zero_a) res_nxt = {sa ^ sb, 63'd0};
              else begin
                done_nxt  = 1'b0;
                ua_nxt    = {55'd0, ma};
                ub_nxt    = {55'd0, mb};
                m_nxt     = '0;
                e_nxt     = ea - eb;
                sgn_nxt   = sa ^ sb;
                state_nxt = F_DNA;
              end
            end
            FOP_SQRT: begin
              if (nan_a) res_nxt = req_i.a | QUIET_BIT;
              else if (zero_a) res_nxt = req_i.a;
              else if (sa) res_nxt = DEF_NAN;
              else if (inf_a) res_nxt = req_i.a;
              else begin
                done_nxt = 1'b0;
                ub_nxt   = {55'd0, ma};
                if (req_i.a[62:52] == 11'd0) begin
                  e_nxt     = -14'sd1074;
                  state_nxt = F_SNRM;
                end else begin
                  e_nxt     = $signed({3'b000, req_i.a[62:52]}) - 14'sd1075;
                  state_nxt = F_SODD;
                end
              end
            end
            default: res_nxt = res_r;
          endcase
        end
      end
      F_MUL: begin
        ua_nxt  = {ua_r[106:0], 1'b0};
        ub_nxt  = {1'b0, ub_r[107:1]};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          m_nxt     = {acc[106:0], 1'b0};
          state_nxt = F_NORM;
        end else begin
          m_nxt = acc;
        end
      end
      F_ADD: begin
        if (sgn_r == ssm_r) begin
          m_nxt     = asum;
          state_nxt = F_NORM;
        end else if (ua_r == ub_r) begin
          res_nxt   = 64'd0;
          done_nxt  = 1'b1;
          state_nxt = F_IDLE;
        end else begin
          m_nxt     = adif;
          sgn_nxt   = (ua_r > ub_r) ? sgn_r : ssm_r;
          state_nxt = F_NORM;
        end
      end
      F_DNA: begin
        if (!ua_r[52]) begin
          ua_nxt = {ua_r[106:0], 1'b0};
          e_nxt  = e_r - 14'sd1;
        end else begin
          state_nxt = F_DNB;
        end
      end
      F_DNB: begin
        if (!ub_r[52]) begin
          ub_nxt = {ub_r[106:0], 1'b0};
          e_nxt  = e_r + 14'sd1;
        end else begin
          cnt_nxt   = 6'd56;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        ua_nxt  = {dr[106:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          m_nxt     = {2'b00, m_r[54:0], dr != ua_r, 50'd0};
          stk_nxt   = dr != 108'd0;
          state_nxt = F_NORM;
        end else begin
          m_nxt = {52'd0, m_r[54:0], dr != ua_r};
        end
      end
      F_SNRM: begin
        if (!ub_r[52]) begin
          ub_nxt = {ub_r[106:0], 1'b0};
          e_nxt  = e_r - 14'sd1;
        end else begin
          state_nxt = F_SODD;
        end
      end
      F_SODD: begin
        if (e_r[0]) begin
          ub_nxt = {ub_r[106:0], 1'b0};
          e_nxt  = e_r - 14'sd1;
        end
        ua_nxt    = '0;
        m_nxt     = '0;
        cnt_nxt   = 6'd54;
        state_nxt = F_SQ;
      end
      F_SQ: begin
        ub_nxt  = {ub_r[105:0], 2'b00};
        ua_nxt  = {48'd0, sge ? remn - tq : remn};
        m_nxt   = {54'd0, m_r[52:0], sge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) state_nxt = F_SFIN;
      end
      F_SFIN: begin
        if (m_r[0] && ((ua_r[59:0] != 60'd0) || smant[0])) begin
          if (smant == 53'h1F_FFFF_FFFF_FFFF) begin
            res_nxt = {1'b0, sexp[10:0] + 11'd1, 52'd0};
          end else begin
            res_nxt = {1'b0, sexp[10:0], smant[51:0] + 52'd1};
          end
        end else begin
          res_nxt = {1'b0, sexp[10:0], smant[51:0]};
        end
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end
      F_NORM: begin
        priority if (m_r[107:106] != 2'b00) begin
          m_nxt   = {1'b0, m_r[107:1]};
          stk_nxt = stk_r | m_r[0];
          e_nxt   = e_r + 14'sd1;
        end else if (e_r < EXP_TINY) begin
          stk_nxt = stk_r | (m_r != 108'd0);
          m_nxt   = '0;
          e_nxt   = EXP_MIN;
        end else if (e_r < EXP_MIN) begin
          m_nxt   = {1'b0, m_r[107:1]};
          stk_nxt = stk_r | m_r[0];
          e_nxt   = e_r + 14'sd1;
        end else if (!m_r[105] && (m_r != 108'd0) && (e_r > EXP_MIN)) begin
          m_nxt = {m_r[106:0], 1'b0};
          e_nxt = e_r - 14'sd1;
        end else begin
          state_nxt = F_RND;
        end
      end
      F_RND: begin
        if (ee > EXP_MAX) res_nxt = {sgn_r, 11'h7FF, 52'd0};
        else if (mr[53]) res_nxt = {sgn_r, bsum[10:0], 52'd0};
        else if (mr[52]) res_nxt = {sgn_r, bsum[10:0], mr[51:0]};
        else res_nxt = {sgn_r, 11'd0, mr[51:0]};
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
      ua_r    <= '0;
      ub_r    <= '0;
      m_r     <= '0;
      e_r     <= '0;
      sgn_r   <= 1'b0;
      ssm_r   <= 1'b0;
      stk_r   <= 1'b0;
      cnt_r   <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      ua_r    <= ua_nxt;
      ub_r    <= ub_nxt;
      m_r     <= m_nxt;
      e_r     <= e_nxt;
      sgn_r   <= sgn_nxt;
      ssm_r   <= ssm_nxt;
      stk_r   <= stk_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

### hw/rtl/scaled_vector_norm_unit.sv
// Scaled Euclidean norm over a stream of double elements, three-stage scaling.
// A sequencer drives one shared iterative unit (svn_fpu); depends on svn_pkg.
// One element at a time: a multiply runs 53 steps, a divide 56 plus operand normalize, an
// add one step, each then a shift-per-cycle normalize. The closing element adds a square
// root, then by stage a divide, nothing, or a multiply and (if in bound) a divide.
// Synchronous reset: registers at reset values, stage one, sum +0.0, no request.
`timescale 1ns / 1ps

module scaled_vector_norm_unit import svn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SQ, S_ACC, S_ACCD, S_DIV2, S_SET1, S_MUL2,
    S_SET2, S_END, S_ROOT, S_CMP, S_RESF, S_OUT, S_WAIT
  } state_t;

  typedef enum logic [1:0] {
    STG_ONE,
    STG_TWO,
    STG_THREE
  } stage_t;

  state_t      state_r, state_nxt, ret_r, ret_nxt;
  stage_t      stage_r, stage_nxt;
  fpu_req_t    req_r, req_nxt;
  fpu_rsp_t    rsp;
  logic [63:0] sum_r, sum_nxt, x_r, x_nxt, rt_r, rt_nxt, nrm_r, nrm_nxt;
  logic        last_r, last_nxt, ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic [63:0] sscale_r, lscale_r, slimit_r, mlimit_r, obound_r;
  logic [63:0] mag;
  logic        lt_small, lt_mid;

  function automatic fpu_req_t mk_req(input fop_t op, input logic [63:0] a,
                                      input logic [63:0] b);
    fpu_req_t r;
    r.start = 1'b1;
    r.op    = op;
    r.a     = a;
    r.b     = b;
    return r;
  endfunction

  svn_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (req_r),
    .rsp_o (rsp)
  );

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign mag       = {1'b0, x_r[62:0]};
  assign lt_small  = fp_lt(mag, slimit_r);
  assign lt_mid    = fp_lt(mag, mlimit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sscale_r <= ONE_BITS;
      lscale_r <= ONE_BITS;
      slimit_r <= 64'd0;
      mlimit_r <= 64'd0;
      obound_r <= ONE_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMALL_SCALE:    sscale_r <= cfg_data;
        REG_LARGE_SCALE:    lscale_r <= cfg_data;
        REG_SMALL_LIMIT:    slimit_r <= cfg_data;
        REG_MID_LIMIT:      mlimit_r <= cfg_data;
        REG_OVERFLOW_BOUND: obound_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    stage_nxt     = stage_r;
    req_nxt       = '0;
    sum_nxt       = sum_r;
    x_nxt         = x_r;
    last_nxt      = last_r;
    rt_nxt        = rt_r;
    nrm_nxt       = nrm_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_data.element;
          last_nxt  = in_data.last;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_WAIT;
        unique case (stage_r)
          STG_ONE: begin
            if (lt_small) begin
              req_nxt = mk_req(FOP_MUL, lscale_r, x_r);
              ret_nxt = S_SQ;
            end else begin
              req_nxt = mk_req(FOP_DIV, sum_r, lscale_r);
              ret_nxt = S_DIV2;
            end
          end
          STG_TWO: begin
            if (lt_mid) begin
              req_nxt = mk_req(FOP_MUL, x_r, x_r);
              ret_nxt = S_ACC;
            end else begin
              req_nxt = mk_req(FOP_MUL, sum_r, sscale_r);
              ret_nxt = S_MUL2;
            end
          end
          default: begin
            req_nxt = mk_req(FOP_MUL, sscale_r, x_r);
            ret_nxt = S_SQ;
          end
        endcase
      end
      S_SQ: begin
        req_nxt   = mk_req(FOP_MUL, rsp.res, rsp.res);
        ret_nxt   = S_ACC;
        state_nxt = S_WAIT;
      end
      S_ACC: begin
        req_nxt   = mk_req(FOP_ADD, sum_r, rsp.res);
        ret_nxt   = S_ACCD;
        state_nxt = S_WAIT;
      end
      S_ACCD: begin
        sum_nxt   = rsp.res;
        state_nxt = S_END;
      end
      S_DIV2: begin
        req_nxt   = mk_req(FOP_DIV, rsp.res, lscale_r);
        ret_nxt   = S_SET1;
        state_nxt = S_WAIT;
      end
      S_SET1: begin
        sum_nxt   = rsp.res;
        stage_nxt = STG_TWO;
        state_nxt = S_DISP;
      end
      S_MUL2: begin
        req_nxt   = mk_req(FOP_MUL, rsp.res, sscale_r);
        ret_nxt   = S_SET2;
        state_nxt = S_WAIT;
      end
      S_SET2: begin
        sum_nxt   = rsp.res;
        stage_nxt = STG_THREE;
        state_nxt = S_DISP;
      end
      S_END: begin
        if (last_r) begin
          req_nxt   = mk_req(FOP_SQRT, sum_r, 64'd0);
          ret_nxt   = S_ROOT;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ROOT: begin
        rt_nxt = rsp.res;
        unique case (stage_r)
          STG_ONE: begin
            req_nxt   = mk_req(FOP_DIV, rsp.res, lscale_r);
            ret_nxt   = S_RESF;
            state_nxt = S_WAIT;
          end
          STG_TWO: begin
            nrm_nxt   = rsp.res;
            ovf_nxt   = 1'b0;
            state_nxt = S_OUT;
          end
          default: begin
            req_nxt   = mk_req(FOP_MUL, obound_r, sscale_r);
            ret_nxt   = S_CMP;
            state_nxt = S_WAIT;
          end
        endcase
      end
      S_CMP: begin
        if (fp_lt(rt_r, rsp.res)) begin
          req_nxt   = mk_req(FOP_DIV, rt_r, sscale_r);
          ret_nxt   = S_RESF;
          state_nxt = S_WAIT;
        end else begin
          nrm_nxt   = obound_r;
          ovf_nxt   = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_RESF: begin
        nrm_nxt   = rsp.res;
        ovf_nxt   = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.norm     = nrm_r;
          out_data_nxt.overflow = ovf_r;
          sum_nxt               = 64'd0;
          stage_nxt             = STG_ONE;
          state_nxt             = S_IDLE;
        end
      end
      S_WAIT: begin
        if (rsp.done) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      stage_r     <= STG_ONE;
      req_r       <= '0;
      sum_r       <= 64'd0;
      out_valid_r <= 1'b0;
      x_r         <= 64'd0;
      last_r      <= 1'b0;
      rt_r        <= 64'd0;
      nrm_r       <= 64'd0;
      ovf_r       <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      stage_r     <= stage_nxt;
      req_r       <= req_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      last_r      <= last_nxt;
      rt_r        <= rt_nxt;
      nrm_r       <= nrm_nxt;
      ovf_r       <= ovf_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == S_WAIT)
    else $error("result from shared unit outside wait state");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after taking a request");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result shown without finishing a vector");

  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    req_r.start |=> !req_r.start)
    else $error("shared unit started twice in a row");

endmodule

### tb/scaled_vector_norm_unit_test.sv
// Self-checking testbench for scaled_vector_norm_unit: predicts each norm with an
// internal double-precision model of the three-stage scaled sum and compares.
// Depends on svn_pkg and the scaled_vector_norm_unit RTL.
`timescale 1ns / 1ps

module scaled_vector_norm_unit_test;
  import svn_pkg::*;

  localparam bit [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
  localparam bit [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam bit [63:0] HIDDEN    = 64'h0010_0000_0000_0000;
  localparam bit [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
  localparam bit [63:0] MAX_DBL   = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam int        STALL_LIMIT = 40000;
  localparam int        SETTLE_CYCLES = 2000;

  typedef enum bit [1:0] {STG_SMALL, STG_MID, STG_LARGE, STG_SPARE} stage_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  scaled_vector_norm_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model registers and state
  bit [63:0] dn_scale, up_scale, lo_limit, hi_limit, ovf_bound;
  stage_t    norm_stage;
  bit [63:0] sum_bits;
  out_item_t expected_norms[$];
  int        mismatches;
  bit        calm;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit lt_dbl(input bit [63:0] a, input bit [63:0] b);
    bit an, bn;
    an = (a[62:52] == 11'h7FF) && (a[51:0] != 0);
    bn = (b[62:52] == 11'h7FF) && (b[51:0] != 0);
    if (an || bn || (a[62:0] == 0 && b[62:0] == 0)) return 1'b0;
    if (a[63] != b[63]) return a[63];
    if (!a[63]) return a[62:0] < b[62:0];
    return a[62:0] > b[62:0];
  endfunction

  function automatic bit [63:0] div_dbl(input bit [63:0] a, input bit [63:0] b);
    if (b[62:0] != 0) return $realtobits($bitstoreal(a) / $bitstoreal(b));
    if (a[62:52] == 11'h7FF && a[51:0] != 0) return a | QUIET_BIT;
    if (a[62:0] == 0) return DEF_NAN;
    return ((a ^ b) & SIGN_MASK) | POS_INF;
  endfunction

  function automatic bit [63:0] mul_dbl(input bit [63:0] a, input bit [63:0] b);
    return $realtobits($bitstoreal(a) * $bitstoreal(b));
  endfunction

  function automatic bit [63:0] add_dbl(input bit [63:0] a, input bit [63:0] b);
    return $realtobits($bitstoreal(a) + $bitstoreal(b));
  endfunction

  function automatic bit [63:0] sqrt_dbl(input bit [63:0] x);
    bit [10:0] ex;
    longint unsigned m, q, rem, mant, pair, t;
    int e, i, biased;
    ex = x[62:52];
    q = 0;
    rem = 0;
    if (ex == 11'h7FF) begin
      if (x[51:0] != 0) return x | QUIET_BIT;
      if (x[63]) return DEF_NAN;
      return x;
    end
    if (x[62:0] == 0) return x;
    if (x[63]) return DEF_NAN;
    if (ex == 0) begin
      m = x & FRAC_MASK;
      e = -1074;
      while (m < HIDDEN) begin
        m = m << 1;
        e--;
      end
    end else begin
      m = (x & FRAC_MASK) | HIDDEN;
      e = int'(ex) - 1075;
    end
    if (e % 2 != 0) begin
      m = m << 1;
      e--;
    end
    for (i = 53; i >= 0; i--) begin
      pair = (i >= 27) ? ((m >> (2 * i - 54)) & 3) : 0;
      rem = (rem << 2) | pair;
      t = (q << 2) | 1;
      if (rem >= t) begin
        rem -= t;
        q = (q << 1) | 1;
      end else begin
        q = q << 1;
      end
    end
    mant = q >> 1;
    biased = (e - 54) / 2 + 1 + 52 + 1023;
    if ((q & 1) && (rem != 0 || (mant & 1))) mant++;
    if (mant >= (HIDDEN << 1)) begin
      mant = mant >> 1;
      biased++;
    end
    return (64'(biased) << 52) | (mant & FRAC_MASK);
  endfunction

  task automatic accumulate_element(input in_item_t req);
    bit [63:0] mag, p, r;
    out_item_t res;
    mag = req.element & ~SIGN_MASK;
    if (norm_stage == STG_SMALL) begin
      if (lt_dbl(mag, lo_limit)) begin
        p = mul_dbl(up_scale, req.element);
        sum_bits = add_dbl(sum_bits, mul_dbl(p, p));
      end else begin
        sum_bits = div_dbl(div_dbl(sum_bits, up_scale), up_scale);
        norm_stage = STG_MID;
      end
    end
    if (norm_stage == STG_MID) begin
      if (lt_dbl(mag, hi_limit)) begin
        sum_bits = add_dbl(sum_bits, mul_dbl(req.element, req.element));
      end else begin
        sum_bits = mul_dbl(mul_dbl(sum_bits, dn_scale), dn_scale);
        norm_stage = STG_LARGE;
      end
    end
    if (norm_stage >= STG_LARGE) begin
      p = mul_dbl(dn_scale, req.element);
      sum_bits = add_dbl(sum_bits, mul_dbl(p, p));
    end
    if (!req.last) return;
    r = sqrt_dbl(sum_bits);
    res.overflow = 1'b0;
    if (norm_stage == STG_SMALL) res.norm = div_dbl(r, up_scale);
    else if (norm_stage == STG_MID) res.norm = r;
    else if (lt_dbl(r, mul_dbl(ovf_bound, dn_scale))) res.norm = div_dbl(r, dn_scale);
    else begin
      res.norm = ovf_bound;
      res.overflow = 1'b1;
    end
    expected_norms.push_back(res);
    norm_stage = STG_SMALL;
    sum_bits = 64'd0;
  endtask

  task automatic report(input string what, input bit [63:0] got, input bit [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) accumulate_element(in_data);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_norms.size() == 0) begin
        report("unexpected result norm", out_data.norm, 64'd0);
      end else begin
        want = expected_norms.pop_front();
        if (out_data.norm !== want.norm) report("norm", out_data.norm, want.norm);
        if (out_data.overflow !== want.overflow)
          report("overflow", 64'(out_data.overflow), 64'(want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("scaled_vector_norm_unit_test failed");
      $finish;
    end
  end

  task automatic set_regs(input bit [63:0] v0, input bit [63:0] v1, input bit [63:0] v2,
                          input bit [63:0] v3, input bit [63:0] v4);
    bit [63:0] vals[5];
    vals = '{v0, v1, v2, v3, v4};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    // out-of-range index: must be dropped
    cfg_index <= CFG_IDX_W'(3'd7);
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    dn_scale = v0;
    up_scale = v1;
    lo_limit = v2;
    hi_limit = v3;
    ovf_bound = v4;
  endtask

  task automatic send_request(input bit [63:0] element, input bit last);
    in_valid <= 1'b1;
    in_data <= '{element: element, last: last};
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_norms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bit [63:0] pick_element();
    bit [63:0] frac;
    int kind;
    frac = {$urandom, $urandom};
    kind = $urandom_range(99);
    if (kind < 25) return {1'($urandom), 11'($urandom_range(200, 500)), frac[51:0]};
    if (kind < 60) return {1'($urandom), 11'($urandom_range(800, 1250)), frac[51:0]};
    if (kind < 80) return {1'($urandom), 11'($urandom_range(1550, 1900)), frac[51:0]};
    if (kind < 85) return {1'($urandom), 11'd0, frac[51:0]};
    if (kind < 88) return {1'($urandom), 11'h7FF, 52'd0};
    if (kind < 90) return {1'($urandom), 11'h7FF, frac[51:0] | 52'd1};
    return {$urandom, $urandom};
  endfunction

  task automatic send_vector(input int len);
    for (int i = 0; i < len; i++) send_request(pick_element(), i == len - 1);
  endtask

  task automatic test_reset_defaults();
    send_request(64'd0, 1'b1);
    send_request(ONE_BITS, 1'b1);
    send_request(64'h4000_0000_0000_0000, 1'b0);
    send_request(64'hC000_0000_0000_0000, 1'b0);
    send_request(64'h3FE0_0000_0000_0000, 1'b1);
    settle();
  endtask

  task automatic test_directed();
    // typical scaling: s = 2^-600, S = 2^600, y = 2^-500, Y = 2^500
    set_regs(64'h1A70_0000_0000_0000, 64'h6570_0000_0000_0000,
             64'h20B0_0000_0000_0000, 64'h5F30_0000_0000_0000, MAX_DBL);
    send_request(64'h2000_0000_0000_0000, 1'b1);            // stays small
    send_request(64'h3FF8_0000_0000_0000, 1'b0);            // mid
    send_request(64'hC010_0000_0000_0000, 1'b1);
    send_request(64'h2000_0000_0000_0000, 1'b0);            // small to mid to large
    send_request(64'h4000_0000_0000_0000, 1'b0);
    send_request(64'h7000_0000_0000_0000, 1'b1);
    send_request(MAX_DBL, 1'b0);                            // overflow
    send_request(64'hFFEF_FFFF_FFFF_FFFF, 1'b1);
    send_request(64'h0000_0000_0000_0001, 1'b1);            // smallest subnormal
    send_request(64'h7FF8_0000_0000_0001, 1'b1);            // NaN element
    send_request(64'hFFF0_0000_0000_0000, 1'b1);            // minus infinity
    send_request(64'h8000_0000_0000_0000, 1'b1);            // minus zero
    settle();
    // zero scales: division by zero
    set_regs(64'd0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
             64'h7FF0_0000_0000_0000, 64'd0);
    send_request(64'h4000_0000_0000_0000, 1'b1);
    send_request(64'd0, 1'b1);
    send_request(64'h7FF0_0000_0000_0000, 1'b1);
    settle();
    // all ones registers: NaN everywhere
    set_regs('1, '1, '1, '1, '1);
    send_request(ONE_BITS, 1'b0);
    send_request('1, 1'b1);
    settle();
  endtask

  task automatic test_random_vectors(input int vectors);
    for (int v = 0; v < vectors; v++) begin
      if (v == vectors / 2) begin
        // hold until the pipeline drains once
        in_valid <= 1'b0;
        while (expected_norms.size() != 0) @(posedge clk);
      end
      send_vector($urandom_range(6, 1));
    end
    settle();
  endtask

  task automatic test_random_settings();
    set_regs(64'h1A70_0000_0000_0000, 64'h6570_0000_0000_0000,
             64'h20B0_0000_0000_0000, 64'h5F30_0000_0000_0000, MAX_DBL);
    test_random_vectors(70);
    // small bound on the result: frequent overflow
    set_regs(64'h1A70_0000_0000_0000, 64'h6570_0000_0000_0000,
             64'h20B0_0000_0000_0000, 64'h5F30_0000_0000_0000, 64'h7000_0000_0000_0000);
    calm = 1'b1;
    test_random_vectors(60);
    calm = 1'b0;
    for (int k = 0; k < 3; k++) begin
      set_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom});
      test_random_vectors(30);
    end
    set_regs(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
    test_random_vectors(20);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    dn_scale = ONE_BITS;
    up_scale = ONE_BITS;
    lo_limit = 64'd0;
    hi_limit = 64'd0;
    ovf_bound = ONE_BITS;
    norm_stage = STG_SMALL;
    sum_bits = 64'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_settings();
    if (mismatches == 0) begin
      $display("scaled_vector_norm_unit_test passed");
    end else begin
      $display("scaled_vector_norm_unit_test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/svn_pkg.sv
hw/rtl/svn_fpu.sv
hw/rtl/scaled_vector_norm_unit.sv
tb/scaled_vector_norm_unit_test.sv
